// ----- design/led_blink_pattern_generator_macros.svh -----
// Assertion macros shared by the LED pattern generator modules.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef LED_BLINK_PATTERN_GENERATOR_MACROS_SVH
`define LED_BLINK_PATTERN_GENERATOR_MACROS_SVH

// Property holds at every clock edge outside reset.
`define LBPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define LBPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lbpg_pkg.sv -----
// Shared types and constants for the LED pattern generator.
// No dependencies; used by the interfaces, the core and the top level.
package lbpg_pkg;

  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 3;
  localparam int unsigned PAT_W     = 3;
  localparam bit          ACTIVE_LOW_DEF = 1'b0;

  // Phase periods and pattern windows, in ms
  localparam logic [10:0] SLOW_PERIOD      = 11'd2000;
  localparam logic [10:0] SLOW_ON          = 11'd120;
  localparam logic [8:0]  FAST_PERIOD      = 9'd400;
  localparam logic [8:0]  FAST_ON          = 9'd200;
  localparam logic [10:0] DOUBLE_PERIOD    = 11'd1200;
  localparam logic [10:0] DOUBLE_ON1       = 11'd100;
  localparam logic [10:0] DOUBLE_ON2_START = 11'd220;
  localparam logic [10:0] DOUBLE_ON2_END   = 11'd320;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_PRESENT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PRESENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_PRESENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PATTERN   = 3'd4;

  // Status pattern codes
  localparam logic [PAT_W-1:0] PAT_OFF    = 3'd0;
  localparam logic [PAT_W-1:0] PAT_SOLID  = 3'd1;
  localparam logic [PAT_W-1:0] PAT_SLOW   = 3'd2;
  localparam logic [PAT_W-1:0] PAT_FAST   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_DOUBLE = 3'd4;

  // Request actions
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_PULSE = 1'b1;

  typedef struct packed {
    logic             led_enable;
    logic             power_present;
    logic             status_present;
    logic             activity_present;
    logic [PAT_W-1:0] status_pattern;
  } lbpg_cfg_t;

  typedef struct packed {
    logic power;
    logic status;
    logic activity;
  } lbpg_leds_t;

endpackage

// ----- design/lbpg_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on lbpg_pkg for payload widths.
interface lbpg_in_if;
  import lbpg_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [PULSE_W-1:0] pulse_ms;
  modport source (output valid, output action, output pulse_ms, input ready);
  modport sink   (input valid, input action, input pulse_ms, output ready);
endinterface

interface lbpg_out_if;
  logic valid;
  logic ready;
  logic power_level;
  logic status_level;
  logic activity_level;
  modport source (output valid, output power_level, output status_level,
                  output activity_level, input ready);
  modport sink   (input valid, input power_level, input status_level,
                  input activity_level, output ready);
endinterface

interface lbpg_cfg_if;
  import lbpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/lbpg_core.sv -----
// Phase counters, activity one-shot and status LED state.
// Depends on lbpg_pkg and the assertion macro header.
`include "led_blink_pattern_generator_macros.svh"

module lbpg_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        action,
  input  logic [lbpg_pkg::PULSE_W-1:0] pulse_ms,
  input  lbpg_pkg::lbpg_cfg_t         cfg,
  input  logic                        disable_clr,
  output lbpg_pkg::lbpg_leds_t        leds
);
  import lbpg_pkg::*;

  logic [10:0]        slow_phase_r, slow_phase_nxt;
  logic [8:0]         fast_phase_r, fast_phase_nxt;
  logic [10:0]        double_phase_r, double_phase_nxt;
  logic               pulse_active_r, pulse_active_nxt;
  logic [PULSE_W-1:0] pulse_remaining_r, pulse_remaining_nxt;
  logic               status_lit_r, status_lit_nxt;
  logic               pattern_on;

  // Pattern level from the advanced phases
  always_comb begin
    case (cfg.status_pattern)
      PAT_SOLID:  pattern_on = 1'b1;
      PAT_SLOW:   pattern_on = slow_phase_nxt < SLOW_ON;
      PAT_FAST:   pattern_on = fast_phase_nxt < FAST_ON;
      PAT_DOUBLE: pattern_on = (double_phase_nxt < DOUBLE_ON1) ||
                               ((double_phase_nxt >= DOUBLE_ON2_START) &&
                                (double_phase_nxt < DOUBLE_ON2_END));
      default:    pattern_on = 1'b0;
    endcase
  end

  always_comb begin
    slow_phase_nxt      = slow_phase_r;
    fast_phase_nxt      = fast_phase_r;
    double_phase_nxt    = double_phase_r;
    pulse_active_nxt    = pulse_active_r;
    pulse_remaining_nxt = pulse_remaining_r;
    status_lit_nxt      = status_lit_r;
    if (action == ACT_TICK) begin
      slow_phase_nxt   = (slow_phase_r == SLOW_PERIOD - 11'd1) ? '0 : slow_phase_r + 11'd1;
      fast_phase_nxt   = (fast_phase_r == FAST_PERIOD - 9'd1) ? '0 : fast_phase_r + 9'd1;
      double_phase_nxt = (double_phase_r == DOUBLE_PERIOD - 11'd1) ? '0
                                                                   : double_phase_r + 11'd1;
      if (pulse_active_r && (pulse_remaining_r != '0)) begin
        pulse_remaining_nxt = pulse_remaining_r - PULSE_W'(1);
      end
      if (cfg.led_enable) begin
        // end the pulse once the countdown has run out
        if (pulse_active_r && (pulse_remaining_nxt == '0)) begin
          pulse_active_nxt = 1'b0;
        end
        if (cfg.status_present) begin
          status_lit_nxt = pattern_on;
        end
      end
    end else if (cfg.led_enable && cfg.activity_present) begin
      pulse_active_nxt    = 1'b1;
      pulse_remaining_nxt = pulse_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_phase_r      <= '0;
      fast_phase_r      <= '0;
      double_phase_r    <= '0;
      pulse_active_r    <= 1'b0;
      pulse_remaining_r <= '0;
      status_lit_r      <= 1'b0;
    end else if (disable_clr) begin
      pulse_active_r <= 1'b0;
      status_lit_r   <= 1'b0;
    end else if (step) begin
      slow_phase_r      <= slow_phase_nxt;
      fast_phase_r      <= fast_phase_nxt;
      double_phase_r    <= double_phase_nxt;
      pulse_active_r    <= pulse_active_nxt;
      pulse_remaining_r <= pulse_remaining_nxt;
      status_lit_r      <= status_lit_nxt;
    end
  end

  // Levels after this request, before pin polarity
  always_comb begin
    leds.power    = cfg.power_present & cfg.led_enable;
    leds.status   = cfg.status_present & status_lit_nxt;
    leds.activity = cfg.activity_present & pulse_active_nxt;
  end

  `LBPG_ASSERT(a_phase_range, (slow_phase_r < SLOW_PERIOD) && (fast_phase_r < FAST_PERIOD) && (double_phase_r < DOUBLE_PERIOD), "phase counter out of range")
  `LBPG_ASSERT(a_pulse_fall, $fell(pulse_active_r) |-> (!$past(rst_n) || $past(disable_clr) || ($past(step) && ($past(action) == ACT_TICK))), "pulse ended without a tick or disable")
  `LBPG_ASSERT_NEXT(a_pulse_start, step && !disable_clr && (action == ACT_PULSE) && cfg.led_enable && cfg.activity_present, pulse_active_r && (pulse_remaining_r == $past(pulse_ms)), "pulse request not loaded")

endmodule

// ----- design/led_blink_pattern_generator.sv -----
// Top level of the indicator LED pattern generator: register file,
// request/result handshake and pin polarity. Depends on lbpg_pkg, lbpg_if
// and lbpg_core.
//
// Each request (a 1 ms tick or an activity pulse start) yields one result
// with the three pin levels. A request is taken every clock cycle while the
// result register is empty or being drained; its result appears in the
// output register in the cycle after it is taken, and a new request is
// accepted while that result waits as long as the result is taken in the
// same cycle. A single result register follows the phase and one-shot update
// logic. Register writes are expected only while no result is outstanding.
`include "led_blink_pattern_generator_macros.svh"

module led_blink_pattern_generator #(
  parameter bit ACTIVE_LOW = lbpg_pkg::ACTIVE_LOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lbpg_in_if.sink    in_chan,
  lbpg_out_if.source out_chan,
  lbpg_cfg_if.sink   cfg_chan
);
  import lbpg_pkg::*;

  lbpg_cfg_t  cfg_r;
  lbpg_leds_t leds;
  logic       in_acc;
  logic       cfg_wr;
  logic       disable_clr;
  logic       out_valid_r;
  logic       power_level_r, status_level_r, activity_level_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;
  assign disable_clr    = cfg_wr && (cfg_chan.index == REG_LED_ENABLE) && !cfg_chan.data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_enable       <= 1'b0;
      cfg_r.power_present    <= 1'b1;
      cfg_r.status_present   <= 1'b1;
      cfg_r.activity_present <= 1'b1;
      cfg_r.status_pattern   <= PAT_OFF;
    end else if (cfg_wr) begin
      case (cfg_chan.index)
        REG_LED_ENABLE:       cfg_r.led_enable       <= cfg_chan.data[0];
        REG_POWER_PRESENT:    cfg_r.power_present    <= cfg_chan.data[0];
        REG_STATUS_PRESENT:   cfg_r.status_present   <= cfg_chan.data[0];
        REG_ACTIVITY_PRESENT: cfg_r.activity_present <= cfg_chan.data[0];
        REG_STATUS_PATTERN:   cfg_r.status_pattern   <= cfg_chan.data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a request whenever the result register is empty or being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  lbpg_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .action      (in_chan.action),
    .pulse_ms    (in_chan.pulse_ms),
    .cfg         (cfg_r),
    .disable_clr (disable_clr),
    .leds        (leds)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      power_level_r    <= leds.power ^ ACTIVE_LOW;
      status_level_r   <= leds.status ^ ACTIVE_LOW;
      activity_level_r <= leds.activity ^ ACTIVE_LOW;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.power_level    = power_level_r;
  assign out_chan.status_level   = status_level_r;
  assign out_chan.activity_level = activity_level_r;

  `LBPG_ASSERT_NEXT(a_accept_result, in_acc, out_valid_r, "accepted request produced no result")
  `LBPG_ASSERT_NEXT(a_power_level, in_acc, out_chan.power_level == (($past(cfg_r.power_present) & $past(cfg_r.led_enable)) ^ ACTIVE_LOW), "power level does not follow enable")
  `LBPG_ASSERT_NEXT(a_disable_write, disable_clr, !cfg_r.led_enable, "disable write not applied")

endmodule
